FILE: rtl/gfc_pkg.sv
// Shared constants, codes and inter-module types for the zero-forcing closure unit.
package gfc_pkg;

    // Graph size and field widths
    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int WORD_W       = 64;
    localparam int CNT_W        = 7;
    localparam int KIND_W       = 3;
    localparam int NODE_RESET   = 64;

    // Input transaction codes
    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE      = 3'd0,
        KIND_SEED      = 3'd1,
        KIND_RUN       = 3'd2,
        KIND_CLR_SEED  = 3'd3,
        KIND_CLR_GRAPH = 3'd4
    } t_kind;

    // Closure word and running counts travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              chg;
        logic [CNT_W-1:0]  size_cnt;
        logic [CNT_W-1:0]  seed_cnt;
    } t_sweep;

    // Graph update broadcast to every cell
    typedef struct packed {
        logic             edge_we;
        logic             clr_graph;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
    } t_load;

endpackage

FILE: rtl/graph_forcing_closure_unit.sv
// Top level: seed/graph load control, chain of vertex cells, sweep loop and result register.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_kind, i_vertex_a, i_vertex_b
//  result    out        o_out_valid / i_out_ready  o_closure_size, o_closure_bits,
//                                                  o_seed_count, o_all_forced
//  config    in         i_cfg_we                   i_cfg_wdata (node_count)
//
// A run sends the closure word once around the chain of MAX_VERTICES cells per sweep, one
// cell per cycle, and repeats the sweep until one makes no change; the number of sweeps is
// at most the vertices in use plus one, the last being the one with no change.
// Inputs are refused while a run is in progress; a finished result waits in the output
// register while loads keep flowing. Reset is synchronous and clears the graph and seeds.
module graph_forcing_closure_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [gfc_pkg::KIND_W-1:0] i_kind,
    input  logic [gfc_pkg::VTX_W-1:0]  i_vertex_a,
    input  logic [gfc_pkg::VTX_W-1:0]  i_vertex_b,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [gfc_pkg::CNT_W-1:0]  o_closure_size,
    output logic [gfc_pkg::WORD_W-1:0] o_closure_bits,
    output logic [gfc_pkg::CNT_W-1:0]  o_seed_count,
    output logic                       o_all_forced,
    input  logic                       i_cfg_we,
    input  logic [gfc_pkg::CNT_W-1:0]  i_cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [gfc_pkg::CNT_W-1:0]  r_node_count;
    logic [gfc_pkg::WORD_W-1:0] r_seed;
    logic [gfc_pkg::WORD_W-1:0] n_seed;
    gfc_pkg::t_sweep            r_inj;
    gfc_pkg::t_sweep            n_inj;
    gfc_pkg::t_sweep            r_fin;
    gfc_pkg::t_sweep            n_fin;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [gfc_pkg::CNT_W-1:0]  r_out_size;
    logic [gfc_pkg::WORD_W-1:0] r_out_bits;
    logic [gfc_pkg::CNT_W-1:0]  r_out_seed;
    logic                       r_out_forced;

    logic [gfc_pkg::CNT_W-1:0]  n_eff;
    logic [gfc_pkg::WORD_W-1:0] mask;
    logic [gfc_pkg::WORD_W-1:0] seed_m;
    logic                       accept;
    logic                       a_ok;
    logic                       b_ok;
    logic                       load_out;
    gfc_pkg::t_load             load;
    gfc_pkg::t_sweep            chain [0:gfc_pkg::MAX_VERTICES];
    gfc_pkg::t_sweep            tail;

    // Vertices in use and their mask
    assign n_eff = (r_node_count > gfc_pkg::CNT_W'(gfc_pkg::MAX_VERTICES)) ?
                   gfc_pkg::CNT_W'(gfc_pkg::MAX_VERTICES) : r_node_count;

    always_comb begin
        for (int i = 0; i < gfc_pkg::WORD_W; i++) begin
            mask[i] = (i < int'(n_eff));
        end
    end

    assign seed_m = r_seed & mask;

    // Input decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign a_ok       = {1'b0, i_vertex_a} < n_eff;
    assign b_ok       = {1'b0, i_vertex_b} < n_eff;

    always_comb begin
        load.edge_we   = accept && (i_kind == gfc_pkg::KIND_EDGE) && a_ok && b_ok &&
                         (i_vertex_a != i_vertex_b);
        load.clr_graph = accept && (i_kind == gfc_pkg::KIND_CLR_GRAPH);
        load.a         = i_vertex_a;
        load.b         = i_vertex_b;
    end

    // Seed set
    always_comb begin
        n_seed = r_seed;
        if (accept && (i_kind == gfc_pkg::KIND_SEED) && a_ok) begin
            n_seed[i_vertex_a] = 1'b1;
        end else if (accept && (i_kind == gfc_pkg::KIND_CLR_SEED)) begin
            n_seed = '0;
        end
    end

    // Cell chain
    assign chain[0] = r_inj;
    assign tail     = chain[gfc_pkg::MAX_VERTICES];

    for (genvar g = 0; g < gfc_pkg::MAX_VERTICES; g++) begin : g_cell
        gfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_id    (gfc_pkg::VTX_W'(g)),
            .i_load  (load),
            .i_mask  (mask),
            .i_seedm (seed_m),
            .i_sweep (chain[g]),
            .o_sweep (chain[g+1])
        );
    end

    // Sweep control: inject, repeat while changed, then hand off the result
    always_comb begin
        n_state       = r_state;
        n_inj         = r_inj;
        n_inj.valid   = 1'b0;
        n_fin         = r_fin;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == gfc_pkg::KIND_RUN)) begin
                    n_inj.valid    = 1'b1;
                    n_inj.word     = seed_m;
                    n_inj.chg      = 1'b0;
                    n_inj.size_cnt = '0;
                    n_inj.seed_cnt = '0;
                    n_state        = ST_RUN;
                end
            end
            ST_RUN: begin
                if (tail.valid) begin
                    if (tail.chg) begin
                        n_inj.valid    = 1'b1;
                        n_inj.word     = tail.word;
                        n_inj.chg      = 1'b0;
                        n_inj.size_cnt = '0;
                        n_inj.seed_cnt = '0;
                    end else begin
                        n_fin   = tail;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= gfc_pkg::CNT_W'(gfc_pkg::NODE_RESET);
            r_seed       <= '0;
            r_inj.valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_inj       <= n_inj;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        if (load_out) begin
            r_out_size   <= r_fin.size_cnt;
            r_out_bits   <= r_fin.word;
            r_out_seed   <= r_fin.seed_cnt;
            r_out_forced <= (r_fin.word == mask);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_closure_size = r_out_size;
    assign o_closure_bits = r_out_bits;
    assign o_seed_count   = r_out_seed;
    assign o_all_forced   = r_out_forced;

endmodule

FILE: rtl/gfc_cell.sv
// One vertex cell: holds its adjacency row, applies the forcing rule to the passing word.
module gfc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gfc_pkg::VTX_W-1:0]  i_id,
    input  gfc_pkg::t_load             i_load,
    input  logic [gfc_pkg::WORD_W-1:0] i_mask,
    input  logic [gfc_pkg::WORD_W-1:0] i_seedm,
    input  gfc_pkg::t_sweep            i_sweep,
    output gfc_pkg::t_sweep            o_sweep
);

    logic [gfc_pkg::WORD_W-1:0] r_row;
    logic [gfc_pkg::WORD_W-1:0] n_row;
    gfc_pkg::t_sweep            r_sweep;
    gfc_pkg::t_sweep            n_sweep;
    logic [gfc_pkg::WORD_W-1:0] open_nbrs;
    logic                       single;
    logic                       force_nbr;

    // Adjacency row update: edges touching this vertex, or full clear
    always_comb begin
        n_row = r_row;
        if (i_load.clr_graph) begin
            n_row = '0;
        end else if (i_load.edge_we) begin
            if (i_load.a == i_id) begin
                n_row[i_load.b] = 1'b1;
            end
            if (i_load.b == i_id) begin
                n_row[i_load.a] = 1'b1;
            end
        end
    end

    // Forcing rule: closed vertex with exactly one open neighbor
    assign open_nbrs = r_row & i_mask & ~i_sweep.word;
    assign single    = (open_nbrs != '0) &&
                       ((open_nbrs & (open_nbrs - gfc_pkg::WORD_W'(1))) == '0);
    assign force_nbr = i_sweep.valid && i_sweep.word[i_id] && single;

    always_comb begin
        n_sweep          = i_sweep;
        n_sweep.word     = force_nbr ? (i_sweep.word | open_nbrs) : i_sweep.word;
        n_sweep.chg      = i_sweep.chg | force_nbr;
        n_sweep.size_cnt = i_sweep.size_cnt + gfc_pkg::CNT_W'(i_sweep.word[i_id]);
        n_sweep.seed_cnt = i_sweep.seed_cnt + gfc_pkg::CNT_W'(i_seedm[i_id]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // Hand the word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep.valid <= 1'b0;
        end else begin
            r_sweep <= n_sweep;
        end
    end

    assign o_sweep = r_sweep;

endmodule

FILE: rtl/gfc_checker.sv
// Port-level checks for the zero-forcing closure unit, bound to the top level.
module gfc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [gfc_pkg::KIND_W-1:0] i_kind,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [gfc_pkg::CNT_W-1:0]  o_closure_size,
    input logic [gfc_pkg::WORD_W-1:0] o_closure_bits,
    input logic [gfc_pkg::CNT_W-1:0]  o_seed_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_closure_bits))
        else $error("result changed while stalled");

    // Size matches the closure bits
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_closure_bits) == 32'(o_closure_size))
        else $error("closure size does not match closure bits");

    // Seeds are contained in the closure
    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_seed_count <= o_closure_size)
        else $error("seed count exceeds closure size");

    // A run transaction blocks the input channel on the next cycle
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == gfc_pkg::KIND_RUN) |=> !o_in_ready)
        else $error("input accepted right after a run started");

endmodule

bind graph_forcing_closure_unit gfc_checker u_gfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_kind         (i_kind),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_closure_size (o_closure_size),
    .o_closure_bits (o_closure_bits),
    .o_seed_count   (o_seed_count)
);
